/* hw/rtl/iowdr_pkg.sv */
// Shared types and constants for the in-order worker dispatch / reorder block.
// No dependencies.
package iowdr_pkg;

  localparam int HANDLE_W = 16;
  localparam int WID_W    = 3;
  localparam int CFG_W    = 4;

  localparam int DEF_BUFFER_DEPTH = 16;
  localparam int DEF_MAX_WORKERS  = 8;

  localparam logic [CFG_W-1:0] ACTIVE_RESET = 4'd8;

  localparam logic REQ_ARRIVE   = 1'b0;
  localparam logic REQ_COMPLETE = 1'b1;

  typedef enum logic [1:0] {
    KIND_DISPATCH = 2'd0,
    KIND_RETIRE   = 2'd1,
    KIND_REFUSED  = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SCAN,
    ST_RETIRE,
    ST_DISPATCH,
    ST_REFUSE
  } state_t;

  // Per-slot completion flags, valid only while the slot's done bit is set.
  typedef struct packed {
    logic skipped;
    logic damaged;
  } flags_t;

  // Worker pool update strobes.
  typedef struct packed {
    logic grant;
    logic free;
  } pool_op_t;

endpackage

/* hw/rtl/in_order_worker_dispatch_reorder.sv */
// In-order worker dispatch with reorder buffer, top level.
// Steps: EXEC, then SCAN with one RETIRE per finished head entry, then DISPATCH; a refusal goes EXEC to REFUSE.
// A new request is taken only back in IDLE, so one is in flight at a time; out_stall holds any result state.
// The rate is set by the sequencer walking the head one slot-memory read at a time.
// Reset (rst, sync): clears pointers, done bits, busy bits and the sequencer;
// handle and flag memories are not cleared and need no clearing pass.
module in_order_worker_dispatch_reorder #(
  parameter int BUFFER_DEPTH = iowdr_pkg::DEF_BUFFER_DEPTH,
  parameter int MAX_WORKERS  = iowdr_pkg::DEF_MAX_WORKERS
) (
  input  logic                           clk,
  input  logic                           rst,
  // configuration
  input  logic                           cfg_write,
  input  logic [iowdr_pkg::CFG_W-1:0]    cfg_data,
  // request channel
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           req_type,
  input  logic [iowdr_pkg::HANDLE_W-1:0] item_handle,
  input  logic [iowdr_pkg::WID_W-1:0]    worker_id,
  input  logic                           worker_failed,
  // result channel
  output logic                           out_valid,
  input  logic                           out_stall,
  output iowdr_pkg::kind_t               result_kind,
  output logic [iowdr_pkg::HANDLE_W-1:0] out_handle,
  output logic [iowdr_pkg::WID_W-1:0]    target_worker,
  output logic                           was_skipped,
  output logic                           damaged,
  output logic                           last
);
  import iowdr_pkg::*;

  localparam int SW = $clog2(BUFFER_DEPTH);
  localparam int OW = $clog2(BUFFER_DEPTH + 1);
  localparam int WW = (MAX_WORKERS > 1) ? $clog2(MAX_WORKERS) : 1;

  // ---------------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------------
  state_t              state, state_next;
  logic [CFG_W-1:0]    active_workers;

  // latched request beat
  logic                req_type_q;
  logic [HANDLE_W-1:0] req_handle;
  logic [WID_W-1:0]    req_wid;
  logic                req_failed;

  // ring pointers and per-slot done bits (done doubles as the valid bit
  // for the flag memory, so that memory needs no reset)
  logic [SW-1:0]           head;
  logic [OW-1:0]           occ;
  logic [BUFFER_DEPTH-1:0] done;

  // work left over from the EXEC step of an arrival
  logic          pend_dispatch;
  logic          pend_skip;
  logic [SW-1:0] pend_tail;
  logic [WW-1:0] disp_worker;

  // ---------------------------------------------------------------------------
  // Submodule wiring
  // ---------------------------------------------------------------------------
  logic                hwe, fwe, mem_re;
  flags_t              fwdata;
  logic [SW-1:0]       fwaddr;
  logic [HANDLE_W-1:0] rhandle;
  flags_t              rflags;

  pool_op_t      pool_op;
  logic [WW-1:0] query_id;
  logic          query_busy;
  logic [SW-1:0] query_slot;
  logic          pick_valid;
  logic [WW-1:0] pick_id;

  // ---------------------------------------------------------------------------
  // Derived values
  // ---------------------------------------------------------------------------
  logic [SW:0]   tail_sum;
  logic [SW-1:0] tail;
  logic [SW-1:0] head_inc;
  logic          is_arrive;
  logic          full;
  logic          in_range;
  logic          comp_hit;
  logic          can_retire;
  logic          more;
  logic          out_free;

  // tail = (head + occ) mod depth; sum stays below twice the depth
  assign tail_sum = (SW+1)'(head) + (SW+1)'(occ);
  assign tail     = (tail_sum >= (SW+1)'(BUFFER_DEPTH))
                  ? SW'(tail_sum - (SW+1)'(BUFFER_DEPTH)) : SW'(tail_sum);
  assign head_inc = (head == SW'(BUFFER_DEPTH - 1)) ? '0 : head + 1'b1;

  assign is_arrive  = (req_type_q == REQ_ARRIVE);
  assign full       = (occ == OW'(BUFFER_DEPTH));
  assign in_range   = (int'(req_wid) < MAX_WORKERS);
  assign query_id   = WW'(req_wid);
  assign comp_hit   = in_range && query_busy;
  assign can_retire = (occ != '0) && done[head];
  // another result follows the retire being issued now
  assign more       = pend_dispatch || ((occ > OW'(1)) && done[head_inc]);
  assign out_free   = !out_valid || !out_stall;

  // ---------------------------------------------------------------------------
  // Sequencer: next state and strobes
  // ---------------------------------------------------------------------------
  logic            push, pop, set_done, skip_mark, out_load;
  kind_t           kind_next;
  logic [HANDLE_W-1:0] handle_next;
  logic [WID_W-1:0]    target_next;
  logic            skipped_next, damaged_next, last_next;

  always_comb begin
    state_next   = state;
    in_stall     = 1'b1;
    hwe          = 1'b0;
    fwe          = 1'b0;
    fwaddr       = tail;
    fwdata       = '{skipped: 1'b1, damaged: 1'b0};
    mem_re       = 1'b0;
    pool_op      = '0;
    push         = 1'b0;
    pop          = 1'b0;
    set_done     = 1'b0;
    skip_mark    = 1'b0;
    out_load     = 1'b0;
    kind_next    = KIND_RETIRE;
    handle_next  = rhandle;
    target_next  = '0;
    skipped_next = 1'b0;
    damaged_next = 1'b0;
    last_next    = 1'b0;

    case (state)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          state_next = ST_EXEC;
        end
      end

      ST_EXEC: begin
        if (is_arrive) begin
          if (full) begin
            state_next = ST_REFUSE;
          end else begin
            // append; skipped entries get done set only after the head walk
            hwe           = 1'b1;
            push          = 1'b1;
            pool_op.grant = pick_valid;
            fwe           = !pick_valid;
            state_next    = ST_SCAN;
          end
        end else if (comp_hit) begin
          pool_op.free = 1'b1;
          set_done     = 1'b1;
          fwe          = 1'b1;
          fwaddr       = query_slot;
          fwdata       = '{skipped: 1'b0, damaged: req_failed};
          state_next   = ST_SCAN;
        end else begin
          state_next = ST_IDLE;   // idle or unknown worker: dropped
        end
      end

      ST_SCAN: begin
        if (can_retire) begin
          mem_re     = 1'b1;
          state_next = ST_RETIRE;
        end else if (pend_dispatch) begin
          state_next = ST_DISPATCH;
        end else begin
          skip_mark  = pend_skip;
          state_next = ST_IDLE;
        end
      end

      ST_RETIRE: begin
        if (out_free) begin
          out_load     = 1'b1;
          pop          = 1'b1;
          kind_next    = KIND_RETIRE;
          handle_next  = rhandle;
          skipped_next = rflags.skipped;
          damaged_next = rflags.damaged;
          last_next    = !more;
          state_next   = ST_SCAN;
        end
      end

      ST_DISPATCH: begin
        if (out_free) begin
          out_load    = 1'b1;
          kind_next   = KIND_DISPATCH;
          handle_next = req_handle;
          target_next = WID_W'(disp_worker);
          last_next   = 1'b1;
          state_next  = ST_IDLE;
        end
      end

      ST_REFUSE: begin
        if (out_free) begin
          out_load    = 1'b1;
          kind_next   = KIND_REFUSED;
          handle_next = req_handle;
          last_next   = 1'b1;
          state_next  = ST_IDLE;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // ---------------------------------------------------------------------------
  // Configuration
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      active_workers <= ACTIVE_RESET;
    end else if (cfg_write) begin
      active_workers <= cfg_data;
    end
  end

  // ---------------------------------------------------------------------------
  // Request latch and arrival bookkeeping (payload, no reset)
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && in_valid) begin
      req_type_q <= req_type;
      req_handle <= item_handle;
      req_wid    <= worker_id;
      req_failed <= worker_failed;
    end
    if (state == ST_EXEC) begin
      pend_tail   <= tail;
      disp_worker <= pick_id;
    end
  end

  // ---------------------------------------------------------------------------
  // Ring control state
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      head          <= '0;
      occ           <= '0;
      done          <= '0;
      pend_dispatch <= 1'b0;
      pend_skip     <= 1'b0;
    end else begin
      if (state == ST_EXEC) begin
        pend_dispatch <= push && pick_valid;
        pend_skip     <= push && !pick_valid;
      end
      if (push) begin
        occ <= occ + 1'b1;
      end
      if (pop) begin
        occ     <= occ - 1'b1;
        head    <= head_inc;
        done[head] <= 1'b0;
      end
      if (set_done) begin
        done[query_slot] <= 1'b1;
      end
      if (skip_mark) begin
        done[pend_tail] <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Output register
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      result_kind   <= kind_next;
      out_handle    <= handle_next;
      target_worker <= target_next;
      was_skipped   <= skipped_next;
      damaged       <= damaged_next;
      last          <= last_next;
    end
  end

  // ---------------------------------------------------------------------------
  // Submodules
  // ---------------------------------------------------------------------------
  iowdr_slot_mem #(
    .DEPTH (BUFFER_DEPTH)
  ) u_slot_mem (
    .clk     (clk),
    .hwe     (hwe),
    .hwaddr  (tail),
    .hwdata  (req_handle),
    .fwe     (fwe),
    .fwaddr  (fwaddr),
    .fwdata  (fwdata),
    .re      (mem_re),
    .raddr   (head),
    .rhandle (rhandle),
    .rflags  (rflags)
  );

  iowdr_worker_pool #(
    .WORKERS (MAX_WORKERS),
    .SLOT_W  (SW)
  ) u_worker_pool (
    .clk            (clk),
    .rst            (rst),
    .active_workers (active_workers),
    .op             (pool_op),
    .grant_slot     (tail),
    .query_id       (query_id),
    .query_busy     (query_busy),
    .query_slot     (query_slot),
    .pick_valid     (pick_valid),
    .pick_id        (pick_id)
  );

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_occ_bound: assert property (@(posedge clk) disable iff (rst)
    occ <= OW'(BUFFER_DEPTH))
    else $error("occupancy exceeds buffer depth");

  a_retire_head_done: assert property (@(posedge clk) disable iff (rst)
    (state == ST_RETIRE) |-> ((occ != '0) && done[head]))
    else $error("retire issued on a head that is not complete");

  a_accept_exec: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> (state == ST_EXEC))
    else $error("accepted beat not executed");

  a_pend_exclusive: assert property (@(posedge clk) disable iff (rst)
    !(pend_dispatch && pend_skip))
    else $error("arrival both dispatched and skipped");

endmodule

/* hw/rtl/iowdr_slot_mem.sv */
// Slot storage: handle memory and completion-flag memory, registered read.
// Depends on iowdr_pkg.
module iowdr_slot_mem #(
  parameter int  DEPTH = iowdr_pkg::DEF_BUFFER_DEPTH,
  localparam int AW    = $clog2(DEPTH)
) (
  input  logic                          clk,
  input  logic                          hwe,
  input  logic [AW-1:0]                 hwaddr,
  input  logic [iowdr_pkg::HANDLE_W-1:0] hwdata,
  input  logic                          fwe,
  input  logic [AW-1:0]                 fwaddr,
  input  iowdr_pkg::flags_t             fwdata,
  input  logic                          re,
  input  logic [AW-1:0]                 raddr,
  output logic [iowdr_pkg::HANDLE_W-1:0] rhandle,
  output iowdr_pkg::flags_t             rflags
);
  import iowdr_pkg::*;

  logic [HANDLE_W-1:0] handle_mem [DEPTH];
  flags_t              flags_mem  [DEPTH];

  always_ff @(posedge clk) begin
    if (hwe) begin
      handle_mem[hwaddr] <= hwdata;
    end
    if (re) begin
      rhandle <= handle_mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (fwe) begin
      flags_mem[fwaddr] <= fwdata;
    end
    if (re) begin
      rflags <= flags_mem[raddr];
    end
  end

endmodule

/* hw/rtl/iowdr_worker_pool.sv */
// Worker pool: busy bits, slot owned by each worker, lowest-idle pick.
// Depends on iowdr_pkg.
module iowdr_worker_pool #(
  parameter int  WORKERS = iowdr_pkg::DEF_MAX_WORKERS,
  parameter int  SLOT_W  = 4,
  localparam int WW      = (WORKERS > 1) ? $clog2(WORKERS) : 1
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [iowdr_pkg::CFG_W-1:0] active_workers,
  input  iowdr_pkg::pool_op_t         op,
  input  logic [SLOT_W-1:0]           grant_slot,
  input  logic [WW-1:0]               query_id,
  output logic                        query_busy,
  output logic [SLOT_W-1:0]           query_slot,
  output logic                        pick_valid,
  output logic [WW-1:0]               pick_id
);
  import iowdr_pkg::*;

  logic [WORKERS-1:0] busy;
  logic [SLOT_W-1:0]  worker_slot [WORKERS];

  // lowest-numbered idle worker inside the active window
  always_comb begin
    pick_valid = 1'b0;
    pick_id    = '0;
    for (int w = WORKERS - 1; w >= 0; w--) begin
      if (!busy[w] && (w < int'(active_workers))) begin
        pick_valid = 1'b1;
        pick_id    = WW'(w);
      end
    end
  end

  assign query_busy = busy[query_id];
  assign query_slot = worker_slot[query_id];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= '0;
    end else begin
      if (op.grant) begin
        busy[pick_id] <= 1'b1;
      end
      if (op.free) begin
        busy[query_id] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (op.grant) begin
      worker_slot[pick_id] <= grant_slot;
    end
  end

endmodule

/* verif/in_order_worker_dispatch_reorder_tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench for in_order_worker_dispatch_reorder: directed, random and
// back-pressure traffic checked against an in-bench reorder/worker-pool predictor.
// Depends on iowdr_pkg and the DUT RTL only.
module in_order_worker_dispatch_reorder_tb;
  import iowdr_pkg::*;

  localparam int DEPTH        = DEF_BUFFER_DEPTH;
  localparam int WORKERS      = DEF_MAX_WORKERS;
  localparam int DRAIN_CYCLES = 16;   // covers a no-result item still in the sequencer
  localparam int HOLD_CYCLES  = 400;  // long result-side hold for the pressure test
  localparam int PHASE_ITEMS  = 57;   // random items per worker setting
  localparam int STEP_MAX     = DEPTH + 1;  // most beats one item can cause
  localparam int DUE_SLOTS    = 64;   // ring of owed beats, well above what can pile up

  // ---------------------------------------------------------------------------
  // DUT signals
  // ---------------------------------------------------------------------------
  logic                clk;
  logic                rst;
  logic                cfg_write;
  logic [CFG_W-1:0]    cfg_data;
  logic                in_valid;
  logic                in_stall;
  logic                req_type;
  logic [HANDLE_W-1:0] item_handle;
  logic [WID_W-1:0]    worker_id;
  logic                worker_failed;
  logic                out_valid;
  logic                out_stall;
  kind_t               result_kind;
  logic [HANDLE_W-1:0] out_handle;
  logic [WID_W-1:0]    target_worker;
  logic                was_skipped;
  logic                damaged;
  logic                last;

  in_order_worker_dispatch_reorder i_dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_write     (cfg_write),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .req_type      (req_type),
    .item_handle   (item_handle),
    .worker_id     (worker_id),
    .worker_failed (worker_failed),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .result_kind   (result_kind),
    .out_handle    (out_handle),
    .target_worker (target_worker),
    .was_skipped   (was_skipped),
    .damaged       (damaged),
    .last          (last)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Predictor state: ordered buffer of in-flight items plus the worker pool.
  // Handles of unoccupied slots are never read, so no clearing is needed.
  // ---------------------------------------------------------------------------
  typedef struct {
    kind_t               kind;
    logic [HANDLE_W-1:0] tag;
    logic [WID_W-1:0]    wid;
    logic                skip;
    logic                bad;
    logic                last;
  } beat_t;

  // result beats the block still owes, oldest at due_rd
  beat_t               due_ring[DUE_SLOTS];
  int unsigned         due_wr;
  int unsigned         due_rd;
  // beats caused by the item being predicted
  beat_t               step_buf[STEP_MAX];
  int unsigned         step_count;

  logic [HANDLE_W-1:0] rob_tag  [DEPTH];
  bit                  rob_done [DEPTH];
  bit                  rob_skip [DEPTH];
  bit                  rob_bad  [DEPTH];
  int unsigned         rob_head;
  int unsigned         rob_count;
  bit                  pool_busy[WORKERS];
  int unsigned         pool_slot[WORKERS];
  logic [CFG_W-1:0]    pool_size = ACTIVE_RESET;

  int  mismatch_count;
  bit  gaps_on = 1'b1;   // sender inserts idle gaps when set
  bit  hold_request;     // asks the result side for one long hold

  function automatic void push_beat(kind_t k, logic [HANDLE_W-1:0] tag, int unsigned wid,
                                    bit skip, bit bad);
    beat_t b;
    b.kind = k;
    b.tag  = tag;
    b.wid  = wid[WID_W-1:0];
    b.skip = skip;
    b.bad  = bad;
    b.last = 1'b0;
    step_buf[step_count] = b;
    step_count++;
  endfunction

  // Retire finished entries from the head, strictly in arrival order.
  function automatic void retire_head_run();
    while (rob_count > 0 && rob_done[rob_head]) begin
      push_beat(KIND_RETIRE, rob_tag[rob_head], 0, rob_skip[rob_head], rob_bad[rob_head]);
      rob_done[rob_head] = 1'b0;
      rob_skip[rob_head] = 1'b0;
      rob_bad[rob_head]  = 1'b0;
      rob_head = (rob_head + 1) % DEPTH;
      rob_count--;
    end
  endfunction

  // Advance the predictor by one accepted request and queue the beats it causes.
  function automatic void dispatch_and_retire(logic req, logic [HANDLE_W-1:0] tag,
                                              logic [WID_W-1:0] wid, logic failed);
    int unsigned tail;
    int unsigned lim;
    int unsigned s;
    bit          placed;
    step_count = 0;
    placed = 1'b0;
    if (req == REQ_ARRIVE) begin
      if (rob_count >= DEPTH) begin
        // full buffer: refuse, nothing else moves
        push_beat(KIND_REFUSED, tag, 0, 1'b0, 1'b0);
      end else begin
        tail = (rob_head + rob_count) % DEPTH;
        rob_tag[tail]  = tag;
        rob_done[tail] = 1'b0;
        rob_skip[tail] = 1'b0;
        rob_bad[tail]  = 1'b0;
        rob_count++;
        retire_head_run();
        // lowest idle worker among the enabled ones; settings above the pool clamp
        lim = (pool_size > WORKERS) ? WORKERS : pool_size;
        for (int w = 0; w < lim && !placed; w++) begin
          if (!pool_busy[w]) begin
            pool_busy[w] = 1'b1;
            pool_slot[w] = tail;
            push_beat(KIND_DISPATCH, tag, w, 1'b0, 1'b0);
            placed = 1'b1;
          end
        end
        // no worker free: finished as skipped, retired on a later request
        if (!placed) begin
          rob_done[tail] = 1'b1;
          rob_skip[tail] = 1'b1;
        end
      end
    end else if (wid < WORKERS && pool_busy[wid]) begin
      // completion from an idle worker is dropped silently
      s = pool_slot[wid];
      rob_done[s] = 1'b1;
      rob_bad[s]  = failed;
      pool_busy[wid] = 1'b0;
      retire_head_run();
    end
    if (step_count > 0) step_buf[step_count - 1].last = 1'b1;
    for (int i = 0; i < step_count; i++) begin
      due_ring[due_wr % DUE_SLOTS] = step_buf[i];
      due_wr++;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------
  task automatic report_mismatch(input string what);
    mismatch_count++;
    if (mismatch_count <= 40) $display("mismatch at %0t: %s", $time, what);
  endtask

  // Every accepted result beat is matched against the oldest owed beat.
  always @(posedge clk) begin : check_beats
    beat_t want;
    if (!rst && out_valid && !out_stall) begin
      if (due_wr == due_rd) begin
        report_mismatch($sformatf("unexpected beat kind %0d handle %h",
                                  result_kind, out_handle));
      end else begin
        want = due_ring[due_rd % DUE_SLOTS];
        due_rd++;
        if (result_kind !== want.kind)
          report_mismatch($sformatf("result_kind %0d, want %0d (handle %h)",
                                    result_kind, want.kind, want.tag));
        if (out_handle !== want.tag)
          report_mismatch($sformatf("out_handle %h, want %h", out_handle, want.tag));
        if (target_worker !== want.wid)
          report_mismatch($sformatf("target_worker %0d, want %0d (handle %h)",
                                    target_worker, want.wid, want.tag));
        if (was_skipped !== want.skip)
          report_mismatch($sformatf("was_skipped %b, want %b (handle %h)",
                                    was_skipped, want.skip, want.tag));
        if (damaged !== want.bad)
          report_mismatch($sformatf("damaged %b, want %b (handle %h)",
                                    damaged, want.bad, want.tag));
        if (last !== want.last)
          report_mismatch($sformatf("last %b, want %b (handle %h)",
                                    last, want.last, want.tag));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Idle-length picks: mostly short, now and then long.
  // ---------------------------------------------------------------------------
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 9);
    return $urandom_range(15, 30);
  endfunction

  // Result side: alternating go and stall runs, one drive per falling edge.
  // A hold request overrides the runs with one long stall.
  initial begin : result_side
    int unsigned run_left;
    int unsigned hold_left;
    bit          stall_phase;
    run_left    = 0;
    hold_left   = 0;
    stall_phase = 1'b1;
    out_stall   = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_left    = HOLD_CYCLES;
        hold_request = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        while (run_left == 0) begin
          stall_phase = !stall_phase;
          if (stall_phase) run_left = pick_gap();
          else if ($urandom_range(0, 9) == 0) run_left = $urandom_range(40, 120);
          else run_left = $urandom_range(1, 12);
        end
        run_left--;
        out_stall <= stall_phase;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Request side
  // ---------------------------------------------------------------------------

  // Offer one request beat, hold it until accepted, predict, then maybe idle.
  // Valid stays high into the next send when no gap is drawn.
  task automatic send_beat(input logic req, input logic [HANDLE_W-1:0] tag,
                           input logic [WID_W-1:0] wid, input logic failed);
    int unsigned gap;
    @(negedge clk);
    in_valid      <= 1'b1;
    req_type      <= req;
    item_handle   <= tag;
    worker_id     <= wid;
    worker_failed <= failed;
    do @(posedge clk); while (in_stall);
    dispatch_and_retire(req, tag, wid, failed);
    gap = gaps_on ? pick_gap() : 0;
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  // Drop valid and wait until every owed beat is out and the sequencer is quiet.
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (due_wr != due_rd) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Register writes only happen with the block idle.
  task automatic set_workers(input logic [CFG_W-1:0] count);
    settle();
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_data  <= count;
    @(posedge clk);
    pool_size = count;
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Extreme handles, out-of-order completion, failure marking, idle-worker
  // completion, a zero worker count and a count above the pool size.
  task automatic test_directed();
    send_beat(REQ_ARRIVE, 16'h0000, 3'd0, 1'b0);     // dispatch to worker 0
    send_beat(REQ_ARRIVE, 16'hFFFF, 3'd7, 1'b1);     // dispatch to worker 1
    send_beat(REQ_COMPLETE, 16'hFFFF, 3'd1, 1'b1);   // younger done first: held back
    send_beat(REQ_COMPLETE, 16'h0000, 3'd0, 1'b0);   // both retire, second damaged
    send_beat(REQ_COMPLETE, 16'h5555, 3'd7, 1'b1);   // idle worker: ignored
    set_workers(4'd0);
    send_beat(REQ_ARRIVE, 16'h1234, 3'd0, 1'b0);     // skipped, nothing out yet
    send_beat(REQ_ARRIVE, 16'hEDCB, 3'd0, 1'b0);     // retires the first skipped one
    set_workers(4'd15);
    send_beat(REQ_ARRIVE, 16'h0F0F, 3'd2, 1'b0);     // retire skipped, dispatch worker 0
    send_beat(REQ_COMPLETE, 16'hF0F0, 3'd0, 1'b0);
  endtask

  // One worker, result side held off: the sender keeps offering arrivals so the
  // buffer fills with skipped items behind a busy head, overflows into refusals
  // and the block stalls its input. Releasing the head retires a full buffer.
  task automatic test_full_buffer_under_hold();
    set_workers(4'd1);
    gaps_on      = 1'b0;
    hold_request = 1'b1;
    send_beat(REQ_ARRIVE, 16'hC000, 3'd0, 1'b0);
    for (int i = 1; i < DEPTH + 4; i++)
      send_beat(REQ_ARRIVE, HANDLE_W'(16'hC000 + i), WID_W'($urandom_range(0, 7)),
                1'($urandom_range(0, 1)));
    send_beat(REQ_COMPLETE, 16'h0000, 3'd0, 1'b1);
    send_beat(REQ_COMPLETE, 16'h0000, 3'd0, 1'b0);   // worker now idle: ignored
    gaps_on = 1'b1;
  endtask

  // Mostly well-formed: arrivals and completions from busy workers; a little
  // noise in the form of completions from any worker id.
  task automatic random_item();
    int unsigned r;
    int unsigned pick;
    int unsigned busy_ids[WORKERS];
    int unsigned busy_n;
    r = $urandom_range(0, 99);
    busy_n = 0;
    foreach (pool_busy[w]) begin
      if (pool_busy[w]) begin
        busy_ids[busy_n] = w;
        busy_n++;
      end
    end
    if (r < 50) begin
      send_beat(REQ_ARRIVE, HANDLE_W'($urandom_range(0, 16'hFFFF)),
                WID_W'($urandom_range(0, 7)), 1'($urandom_range(0, 1)));
    end else if (r < 92 && busy_n > 0) begin
      pick = busy_ids[$urandom_range(0, busy_n - 1)];
      send_beat(REQ_COMPLETE, HANDLE_W'($urandom_range(0, 16'hFFFF)), pick[WID_W-1:0],
                $urandom_range(0, 3) == 0);
    end else begin
      pick = $urandom_range(0, 7);
      send_beat(REQ_COMPLETE, HANDLE_W'($urandom_range(0, 16'hFFFF)), pick[WID_W-1:0],
                1'($urandom_range(0, 1)));
    end
  endtask

  // Random traffic across several worker counts, extremes included. Busy
  // workers left over from one setting keep completing under the next.
  task automatic test_random_traffic();
    logic [CFG_W-1:0] settings[7];
    int unsigned      tries;
    settings = '{4'd8, 4'd1, 4'd3, 4'd0, 4'd15, 4'd2, 4'd8};
    settings[6] = CFG_W'($urandom_range(1, 8));
    foreach (settings[p]) begin
      set_workers(settings[p]);
      tries  = 0;
      while (tries < PHASE_ITEMS) begin
        if (tries % 20 == 0) gaps_on = ($urandom_range(0, 3) != 0);
        random_item();
        tries++;
      end
    end
    gaps_on = 1'b1;
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin : run_tests
    rst           = 1'b1;
    cfg_write     = 1'b0;
    cfg_data      = ACTIVE_RESET;
    in_valid      = 1'b0;
    req_type      = REQ_ARRIVE;
    item_handle   = '0;
    worker_id     = '0;
    worker_failed = 1'b0;
    mismatch_count = 0;
    hold_request  = 1'b0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_directed();
    test_full_buffer_under_hold();
    test_random_traffic();
    settle();

    if (mismatch_count == 0 && due_wr == due_rd) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Hard stop well beyond the slowest legal run.
  initial begin : watchdog
    #12_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule
